// ===== src/lottery_process_scheduler_core_assert.svh =====
// assertion macros for the lottery scheduler checker
`ifndef LOTTERY_PROCESS_SCHEDULER_CORE_ASSERT_SVH
`define LOTTERY_PROCESS_SCHEDULER_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define LSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

    localparam int DEF_NUM_SLOTS = 64;
    localparam logic [31:0] SEED_RESET = 32'd1;
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_INC = 32'd12345;
    localparam int DIV_STEPS = 32;

    localparam logic [7:0] CREATE_PRIO = 8'd10;
    localparam logic [7:0] TK_FIXED = 8'd10;
    localparam logic [7:0] TK_BOOST = 8'd20;
    localparam logic [7:0] WAKE_BONUS = 8'd10;
    localparam logic [7:0] WAKE_LIMIT = 8'd90;

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_SEED_IDX = 1'b0;

    // commands
    localparam logic [2:0] CMD_PICK = 3'd0;
    localparam logic [2:0] CMD_CREATE = 3'd1;
    localparam logic [2:0] CMD_SLEEP = 3'd2;
    localparam logic [2:0] CMD_WAKE = 3'd3;
    localparam logic [2:0] CMD_YIELD = 3'd4;
    localparam logic [2:0] CMD_SET_PRIO = 3'd5;
    localparam logic [2:0] CMD_RELEASE = 3'd6;
    localparam logic [2:0] CMD_POLICY = 3'd7;

    // ticket policies
    localparam logic [1:0] POL_FIXED = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;
    localparam logic [1:0] POL_BOOST = 2'd3;

    typedef enum logic [1:0] {
        ST_FREE = 2'd0,
        ST_SLEEPING = 2'd1,
        ST_RUNNABLE = 2'd2,
        ST_RUNNING = 2'd3
    } slot_state_t;

    typedef struct packed {
        slot_state_t status;
        logic [7:0]  tickets;
        logic [7:0]  prio;
    } slot_entry_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] slot;
        logic [7:0] value;
    } sched_in_t;

    typedef struct packed {
        logic        found;
        logic [5:0]  chosen_slot;
        logic [13:0] ticket_total;
        logic [13:0] drawn_ticket;
    } sched_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SLOT_RD,
        S_SLOT_WR,
        S_SUM,
        S_LCG,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_WALK,
        S_WIN_WR,
        S_POLICY,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic clr;
        logic sum_run;
        logic walk_run;
        logic pol_run;
        logic lcg_step;
        logic div_start;
        logic div_sel;
        logic cap_quot;
        logic cap_rem;
        logic slot_rd;
        logic slot_wr;
        logic win_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd_code;
        logic       slot_ok;
        logic       pol_ok;
        logic       sweep_done;
        logic       walk_done;
        logic       div_done;
    } dp_status_t;

    function automatic logic [7:0] pol_tickets(input logic [1:0] pol,
                                               input logic [7:0] prio,
                                               input logic [7:0] tk);
        case (pol)
            POL_FIXED: return TK_FIXED;
            POL_PRIO:  return prio;
            POL_BOOST: return TK_BOOST;
            default:   return tk;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== src/lsp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module lsp_div
    import lsp_pkg::*;
#(
    parameter int DVS_W = 14
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [31:0]      dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [31:0]           quot,
    output logic [DVS_W-1:0]      rem
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [31:0]      dvd_reg, dvd_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W:0]   trial;
    logic             qbit;

    assign trial = {rem_reg, dvd_reg[31]};
    assign qbit = (trial >= {1'b0, divisor});

    always_comb
    begin
        count_next = count_reg;
        run_next = run_reg;
        done_next = 1'b0;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (start)
        begin
            count_next = CNT_W'(DIV_STEPS);
            run_next = 1'b1;
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[30:0], qbit};
            rem_next = qbit ? DVS_W'(trial - {1'b0, divisor}) : DVS_W'(trial);
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            run_reg <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem = rem_reg;

endmodule

`default_nettype wire

// ===== src/lsp_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsp_dp
    import lsp_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    input  wire sched_in_t  item,
    input  wire logic       seed_wr,
    input  wire logic [31:0] seed_val,
    output sched_out_t      result
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int SUM_W = $clog2(NUM_SLOTS * 255 + 2);

    // slot table, one write and one read port, registered read
    slot_entry_t mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;

    sched_in_t   in_reg;
    logic [1:0]  policy_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic        pend_reg;
    logic [IW-1:0] pend_addr_reg;
    slot_entry_t rd_data_reg;
    logic        rd_valid_reg;
    slot_entry_t entry;

    logic        rd_en;
    logic [IW-1:0] rd_addr;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    slot_entry_t wr_data;
    slot_entry_t slot_upd;

    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0] divisor;
    logic [SUM_W-1:0] t_reg, t_next;
    logic [SUM_W-1:0] draw_reg, draw_next;
    logic [31:0]      lcg_reg, lcg_next;
    logic [31:0]      q_reg;
    logic             found_reg, found_next;
    logic [IW-1:0]    win_addr_reg;
    slot_entry_t      win_entry_reg;

    logic        issue;
    logic [IW-1:0] slot_addr;
    logic        runnable;
    logic [31:0] div_dividend;
    logic        div_done;
    logic [31:0] div_quot;
    logic [SUM_W-1:0] div_rem;

    assign slot_addr = IW'(in_reg.slot);
    assign entry = rd_valid_reg ? rd_data_reg : '0;
    assign runnable = (entry.status == ST_RUNNABLE);

    assign issue = (cmd.sum_run | cmd.pol_run | (cmd.walk_run & ~found_reg))
                   & (idx_reg < CW'(NUM_SLOTS));
    assign rd_en = issue | cmd.slot_rd;
    assign rd_addr = cmd.slot_rd ? slot_addr : IW'(idx_reg);

    // single slot update
    always_comb
    begin
        slot_upd = entry;
        case (in_reg.cmd)
            CMD_CREATE:
            begin
                if (entry.status == ST_FREE)
                begin
                    slot_upd.prio = CREATE_PRIO;
                    slot_upd.tickets = pol_tickets(policy_reg, CREATE_PRIO, entry.tickets);
                    slot_upd.status = ST_RUNNABLE;
                end
            end
            CMD_SLEEP:
            begin
                if (entry.status == ST_RUNNABLE || entry.status == ST_RUNNING)
                    slot_upd.status = ST_SLEEPING;
            end
            CMD_WAKE:
            begin
                if (entry.status == ST_SLEEPING)
                begin
                    slot_upd.status = ST_RUNNABLE;
                    if (policy_reg == POL_BOOST && entry.tickets < WAKE_LIMIT)
                        slot_upd.tickets = entry.tickets + WAKE_BONUS;
                end
            end
            CMD_YIELD:
            begin
                if (entry.status == ST_RUNNING)
                begin
                    slot_upd.status = ST_RUNNABLE;
                    if (policy_reg == POL_BOOST && entry.tickets > 8'd1)
                        slot_upd.tickets = entry.tickets - 8'd1;
                end
            end
            CMD_SET_PRIO:
            begin
                if (entry.status != ST_FREE)
                begin
                    slot_upd.prio = in_reg.value;
                    slot_upd.tickets = in_reg.value;
                end
            end
            CMD_RELEASE:
            begin
                slot_upd.status = ST_FREE;
                slot_upd.tickets = '0;
            end
            default:
            begin
                slot_upd = entry;
            end
        endcase
    end

    // write port select
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = slot_addr;
        wr_data = slot_upd;
        if (cmd.slot_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.pol_run && pend_reg)
        begin
            wr_en = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = entry;
            wr_data.tickets = pol_tickets(in_reg.value[1:0], entry.prio, entry.tickets);
        end
        else if (cmd.win_wr && found_reg)
        begin
            wr_en = 1'b1;
            wr_addr = win_addr_reg;
            wr_data = win_entry_reg;
            wr_data.status = ST_RUNNING;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // sweep, sum, walk
    always_comb
    begin
        idx_next = idx_reg;
        acc_next = acc_reg;
        t_next = t_reg;
        draw_next = draw_reg;
        found_next = found_reg;
        if (cmd.load || cmd.clr)
            idx_next = '0;
        else if (issue)
            idx_next = idx_reg + CW'(1);
        if (cmd.load)
        begin
            acc_next = '0;
            draw_next = '0;
            found_next = 1'b0;
        end
        else
        begin
            if (cmd.sum_run && pend_reg && runnable)
                acc_next = acc_reg + SUM_W'(entry.tickets);
            if (cmd.cap_rem && div_done)
            begin
                t_next = div_rem;
                draw_next = div_rem;
            end
            if (cmd.walk_run && pend_reg && !found_reg && runnable)
            begin
                if (t_reg >= SUM_W'(entry.tickets))
                    t_next = t_reg - SUM_W'(entry.tickets);
                else
                    found_next = 1'b1;
            end
        end
    end

    assign lcg_next = lcg_reg * LCG_MUL + LCG_INC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
            idx_reg <= '0;
            pend_reg <= 1'b0;
            acc_reg <= '0;
            draw_reg <= '0;
            found_reg <= 1'b0;
            lcg_reg <= SEED_RESET;
            policy_reg <= POL_FIXED;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
            idx_reg <= idx_next;
            pend_reg <= issue & ~cmd.load & ~cmd.clr;
            acc_reg <= acc_next;
            draw_reg <= draw_next;
            found_reg <= found_next;
            if (seed_wr)
                lcg_reg <= seed_val;
            else if (cmd.lcg_step)
                lcg_reg <= lcg_next;
            if (cmd.pol_run)
                policy_reg <= in_reg.value[1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= item;
        if (issue)
            pend_addr_reg <= IW'(idx_reg);
        t_reg <= t_next;
        if (cmd.cap_quot && div_done)
            q_reg <= div_quot;
        if (cmd.walk_run && pend_reg && !found_reg && runnable && !(t_reg >= SUM_W'(entry.tickets)))
        begin
            win_addr_reg <= pend_addr_reg;
            win_entry_reg <= entry;
        end
    end

    // draw = ((x >> 1) / (sum + 1)) % (sum + 1)
    assign divisor = acc_reg + SUM_W'(1);
    assign div_dividend = cmd.div_sel ? q_reg : {1'b0, lcg_reg[31:1]};

    lsp_div #(
        .DVS_W(SUM_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(div_dividend),
        .divisor (divisor),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    assign status.cmd_code = in_reg.cmd;
    assign status.slot_ok = (9'(in_reg.slot) < 9'(NUM_SLOTS));
    assign status.pol_ok = (in_reg.value == 8'(POL_FIXED)) || (in_reg.value == 8'(POL_PRIO))
                           || (in_reg.value == 8'(POL_BOOST));
    assign status.sweep_done = (idx_reg == CW'(NUM_SLOTS)) && !pend_reg;
    assign status.walk_done = found_reg || ((idx_reg == CW'(NUM_SLOTS)) && !pend_reg);
    assign status.div_done = div_done;

    assign result.found = found_reg;
    assign result.chosen_slot = found_reg ? 6'(win_addr_reg) : '0;
    assign result.ticket_total = 14'(acc_reg);
    assign result.drawn_ticket = 14'(draw_reg);

endmodule

`default_nettype wire

// ===== src/lsp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsp_ctrl
    import lsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            done
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                case (status.cmd_code)
                    CMD_PICK:   state_next = S_SUM;
                    CMD_POLICY: state_next = status.pol_ok ? S_POLICY : S_DONE;
                    default:    state_next = status.slot_ok ? S_SLOT_RD : S_DONE;
                endcase
            end
            S_SLOT_RD:   state_next = S_SLOT_WR;
            S_SLOT_WR:   state_next = S_DONE;
            S_SUM:
                if (status.sweep_done)
                    state_next = S_LCG;
            S_LCG:       state_next = S_DIV1_GO;
            S_DIV1_GO:   state_next = S_DIV1_WAIT;
            S_DIV1_WAIT:
                if (status.div_done)
                    state_next = S_DIV2_GO;
            S_DIV2_GO:   state_next = S_DIV2_WAIT;
            S_DIV2_WAIT:
                if (status.div_done)
                    state_next = S_WALK;
            S_WALK:
                if (status.walk_done)
                    state_next = S_WIN_WR;
            S_WIN_WR:    state_next = S_DONE;
            S_POLICY:
                if (status.sweep_done)
                    state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:      cmd.load = start;
            S_SLOT_RD:   cmd.slot_rd = 1'b1;
            S_SLOT_WR:   cmd.slot_wr = 1'b1;
            S_SUM:       cmd.sum_run = 1'b1;
            S_LCG:       cmd.lcg_step = 1'b1;
            S_DIV1_GO:   cmd.div_start = 1'b1;
            S_DIV1_WAIT: cmd.cap_quot = 1'b1;
            S_DIV2_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel = 1'b1;
                cmd.clr = 1'b1;
            end
            S_DIV2_WAIT: cmd.cap_rem = 1'b1;
            S_WALK:      cmd.walk_run = 1'b1;
            S_WIN_WR:    cmd.win_wr = 1'b1;
            S_POLICY:    cmd.pol_run = 1'b1;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

// ===== src/lottery_process_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                   | transfer
// ----------+-----------------------------------------+----------------------------------
// command   | start, busy, item                       | start high while busy is low
// result    | done, result                            | one cycle, when done is high
// config    | psel, penable, pwrite, paddr, pwdata,   | write on access cycle, pready
//           | prdata, pready                          | always high
//
// every command gives one result; done pulses for one cycle and busy drops the next cycle
// a slot command reads and then writes its slot (a slot beyond the table is skipped), a
// policy change sweeps the one-read-port slot table one slot per cycle (a bad policy is
// skipped), and a pick makes two table sweeps, summing and then walking to the winner,
// with two passes of the bit-serial divider between them
// reset clears all slots to free through per-slot valid bits, no clearing pass
// the result side cannot stall, so nothing waits on the receiver
module lottery_process_scheduler_core
    import lsp_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire sched_in_t             item,
    // result channel
    output logic                       done,
    output sched_out_t                 result,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic [31:0] seed_reg;
    logic        seed_wr;

    // seed register, a write also reloads the generator
    assign pready = 1'b1;
    assign seed_wr = psel & penable & pwrite & (paddr[2] == REG_SEED_IDX);
    assign prdata = (paddr[2] == REG_SEED_IDX) ? seed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= SEED_RESET;
        else if (seed_wr)
            seed_reg <= pwdata;
    end

    // sequencer
    lsp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(dp_status),
        .cmd   (dp_cmd),
        .busy  (busy),
        .done  (done)
    );

    // slot table, generator, divider and result registers
    lsp_dp #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dp_cmd),
        .status  (dp_status),
        .item    (item),
        .seed_wr (seed_wr),
        .seed_val(pwdata),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== src/lsp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "lottery_process_scheduler_core_assert.svh"

module lsp_checker
    import lsp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire sched_out_t result
);

    `LSP_ASSERT_IMP(a_done_busy, done, busy, "result strobe outside a command")
    `LSP_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "result strobe longer than one cycle")
    `LSP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not start")
    `LSP_ASSERT_IMP(a_no_win_slot, done && !result.found, result.chosen_slot == 6'd0, "slot without winner")
    `LSP_ASSERT_IMP(a_win_draw, done && result.found, result.ticket_total != 14'd0, "winner with no tickets")

endmodule

bind lottery_process_scheduler_core lsp_checker u_lsp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .result(result)
);

`default_nettype wire

// ===== tb/lottery_process_scheduler_core_test.sv =====
`timescale 1ns / 1ps

// testbench for the lottery scheduler core
// commands go in through start/busy, every command gives one result on done
// a local scheduler model predicts each result, which is queued and compared in order
module lottery_process_scheduler_core_test;
    import lsp_pkg::*;

    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    sched_in_t item = '0;
    logic done;
    sched_out_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    lottery_process_scheduler_core #(.NUM_SLOTS(SLOTS)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #10 clk = ~clk;

    // scheduler model state
    slot_state_t mdl_status[SLOTS];
    logic [7:0] mdl_tickets[SLOTS];
    logic [7:0] mdl_prio[SLOTS];
    logic [31:0] mdl_lcg;
    logic [1:0] mdl_policy;

    sched_out_t pending_results[$];
    int mismatches = 0;
    int cycles = 0;
    bit gaps_on = 1'b1;

    function automatic logic [7:0] model_policy_tickets(int idx);
        case (mdl_policy)
            POL_FIXED: return TK_FIXED;
            POL_PRIO:  return mdl_prio[idx];
            POL_BOOST: return TK_BOOST;
            default:   return mdl_tickets[idx];
        endcase
    endfunction

    // apply one command to the model and return its result
    function automatic sched_out_t schedule_step(sched_in_t c);
        sched_out_t r;
        logic [31:0] sum;
        logic [31:0] t;
        int s;
        r = '0;
        s = int'(c.slot);
        case (c.cmd)
            CMD_PICK:
            begin
                sum = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (mdl_status[i] == ST_RUNNABLE)
                        sum += mdl_tickets[i];
                mdl_lcg = mdl_lcg * LCG_MUL + LCG_INC;
                t = (mdl_lcg / (2 * (sum + 1))) % (sum + 1);
                r.ticket_total = sum[13:0];
                r.drawn_ticket = t[13:0];
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (mdl_status[i] == ST_RUNNABLE)
                    begin
                        if (t >= mdl_tickets[i])
                            t -= mdl_tickets[i];
                        else
                        begin
                            mdl_status[i] = ST_RUNNING;
                            r.found = 1'b1;
                            r.chosen_slot = i[5:0];
                            break;
                        end
                    end
                end
            end
            CMD_CREATE:
                if (mdl_status[s] == ST_FREE)
                begin
                    mdl_prio[s] = CREATE_PRIO;
                    mdl_tickets[s] = model_policy_tickets(s);
                    mdl_status[s] = ST_RUNNABLE;
                end
            CMD_SLEEP:
                if (mdl_status[s] == ST_RUNNABLE || mdl_status[s] == ST_RUNNING)
                    mdl_status[s] = ST_SLEEPING;
            CMD_WAKE:
                if (mdl_status[s] == ST_SLEEPING)
                begin
                    mdl_status[s] = ST_RUNNABLE;
                    if (mdl_policy == POL_BOOST && mdl_tickets[s] < WAKE_LIMIT)
                        mdl_tickets[s] = mdl_tickets[s] + WAKE_BONUS;
                end
            CMD_YIELD:
                if (mdl_status[s] == ST_RUNNING)
                begin
                    mdl_status[s] = ST_RUNNABLE;
                    if (mdl_policy == POL_BOOST && mdl_tickets[s] > 8'd1)
                        mdl_tickets[s] = mdl_tickets[s] - 8'd1;
                end
            CMD_SET_PRIO:
                if (mdl_status[s] != ST_FREE)
                begin
                    mdl_prio[s] = c.value;
                    mdl_tickets[s] = c.value;
                end
            CMD_RELEASE:
            begin
                mdl_status[s] = ST_FREE;
                mdl_tickets[s] = 8'd0;
            end
            default:
                if (c.value >= 1 && c.value <= 3)
                begin
                    mdl_policy = c.value[1:0];
                    for (int i = 0; i < SLOTS; i++)
                        mdl_tickets[i] = model_policy_tickets(i);
                end
        endcase
        return r;
    endfunction

    // random idle burst on the command side
    task automatic idle_gap();
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 13)) @(negedge clk);
    endtask

    // one command transfer; the model runs at acceptance
    task automatic send_command(logic [2:0] cmd, logic [5:0] slot, logic [7:0] value);
        sched_in_t c;
        c.cmd = cmd;
        c.slot = slot;
        c.value = value;
        idle_gap();
        @(negedge clk);
        item <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(schedule_step(c));
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // seed register write, only with the block idle
    task automatic write_seed(logic [31:0] val);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mdl_lcg = val;
    endtask

    // result checker: every done must match the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %h", result);
            end
            else
            begin
                sched_out_t exp_r;
                exp_r = pending_results.pop_front();
                if (result.found !== exp_r.found
                    || result.chosen_slot !== exp_r.chosen_slot
                    || result.ticket_total !== exp_r.ticket_total
                    || result.drawn_ticket !== exp_r.drawn_ticket)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected f=%0d s=%0d t=%0d d=%0d, %s",
                                 exp_r.found, exp_r.chosen_slot, exp_r.ticket_total,
                                 exp_r.drawn_ticket,
                                 $sformatf("got f=%0d s=%0d t=%0d d=%0d",
                                           result.found, result.chosen_slot,
                                           result.ticket_total, result.drawn_ticket));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("lottery_process_scheduler_core test failed");
            $finish;
        end
    end

    // directed: extremes, every command, ignored and special cases
    task automatic test_directed();
        send_command(CMD_PICK, 6'd0, 8'd0);          // empty table, no winner
        send_command(CMD_CREATE, 6'd0, 8'd0);
        send_command(CMD_CREATE, 6'd63, 8'd255);
        send_command(CMD_CREATE, 6'd0, 8'd0);        // create on used slot
        send_command(CMD_SET_PRIO, 6'd63, 8'd255);
        send_command(CMD_SET_PRIO, 6'd5, 8'd7);      // free slot, ignored
        send_command(CMD_PICK, 6'd63, 8'd255);
        send_command(CMD_YIELD, 6'd0, 8'd0);
        send_command(CMD_YIELD, 6'd63, 8'd0);
        send_command(CMD_SLEEP, 6'd0, 8'd0);
        send_command(CMD_SLEEP, 6'd1, 8'd0);         // free slot, ignored
        send_command(CMD_POLICY, 6'd0, 8'd3);
        send_command(CMD_WAKE, 6'd0, 8'd0);          // wake with bonus
        send_command(CMD_WAKE, 6'd0, 8'd0);          // not sleeping
        send_command(CMD_POLICY, 6'd0, 8'd0);        // bad policy
        send_command(CMD_POLICY, 6'd0, 8'd255);      // bad policy
        send_command(CMD_PICK, 6'd0, 8'd0);
        send_command(CMD_POLICY, 6'd0, 8'd2);
        send_command(CMD_PICK, 6'd0, 8'd0);
        send_command(CMD_RELEASE, 6'd63, 8'd0);
        send_command(CMD_POLICY, 6'd0, 8'd1);
        send_command(CMD_PICK, 6'd0, 8'd0);
    endtask

    // seed extremes with a few picks on each
    task automatic test_seeds();
        logic [31:0] seeds[3];
        seeds[0] = 32'd0;
        seeds[1] = 32'hFFFF_FFFF;
        seeds[2] = $urandom;
        foreach (seeds[k])
        begin
            write_seed(seeds[k]);
            for (int j = 0; j < 3; j++)
                send_command(CMD_PICK, 6'($urandom), 8'($urandom));
        end
    endtask

    // random commands, biased toward a live table so picks find winners
    task automatic test_random(int count);
        int w;
        logic [2:0] c;
        logic [7:0] v;
        for (int n = 0; n < count; n++)
        begin
            w = $urandom_range(0, 99);
            if (w < 30)      c = CMD_PICK;
            else if (w < 45) c = CMD_CREATE;
            else if (w < 55) c = CMD_SLEEP;
            else if (w < 65) c = CMD_WAKE;
            else if (w < 78) c = CMD_YIELD;
            else if (w < 86) c = CMD_SET_PRIO;
            else if (w < 94) c = CMD_RELEASE;
            else             c = CMD_POLICY;
            v = 8'($urandom);
            if (c == CMD_POLICY && $urandom_range(0, 3) != 0)
                v = 8'($urandom_range(1, 3));
            send_command(c, 6'($urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 11)), v);
            if (n == count / 2)
                wait_drained();               // sender holds off until all results are in
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            mdl_status[i] = ST_FREE;
            mdl_tickets[i] = 8'd0;
            mdl_prio[i] = 8'd0;
        end
        mdl_lcg = SEED_RESET;
        mdl_policy = POL_FIXED;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_seeds();
        test_random(800);
        write_seed($urandom);
        gaps_on = 1'b0;
        test_random(200);
        wait_drained();
        repeat (250) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("lottery_process_scheduler_core test passed");
        else
            $display("lottery_process_scheduler_core test failed");
        $finish;
    end
endmodule

// ===== lottery_process_scheduler_core.f =====
+incdir+src
src/lsp_pkg.sv
src/lsp_div.sv
src/lsp_dp.sv
src/lsp_ctrl.sv
src/lottery_process_scheduler_core.sv
src/lsp_checker.sv
tb/lottery_process_scheduler_core_test.sv
